/* src/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every sampled edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/dlr_pkg.sv */
// shared types, constants and the reciprocal table of the downmix resampler
// no dependencies; imported by every module of the block
package dlr_pkg;

    // sample and phase formats
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_BITS    = 4;
    localparam int PHASE_BITS   = 22;
    localparam int FRAC_BITS    = 16;
    localparam int PHASE_ONE    = 65536;
    localparam int STEP_MIN     = 4096;
    localparam int STEP_MAX     = 2097152;
    localparam int STEP_RESET   = 65536;
    localparam int CHAN_RESET   = 1;

    // channel sum and reciprocal divide
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    // configuration port
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    // queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [CHAN_BITS-1:0]          chan_cnt_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_PHASE_STEP    = 1'b0,
        REG_CHANNEL_COUNT = 1'b1
    } reg_idx_t;

    // configuration seen by front and back
    typedef struct packed {
        phase_t    phase_step;
        chan_cnt_t channel_count;
    } cfg_t;

    // one mono frame waiting for the back end
    typedef struct packed {
        sample_t mono;
        logic    block_end;
    } frame_t;

    // ceil(2^RECIP_SHIFT / n); exact floor division for |sum| below 2^19
    function automatic logic [RECIP_BITS-1:0] recip(input chan_cnt_t n);
        logic [RECIP_BITS-1:0] r;
        case (n)
            4'd1:    r = 23'd4194304;
            4'd2:    r = 23'd2097152;
            4'd3:    r = 23'd1398102;
            4'd4:    r = 23'd1048576;
            4'd5:    r = 23'd838861;
            4'd6:    r = 23'd699051;
            4'd7:    r = 23'd599187;
            4'd8:    r = 23'd524288;
            default: r = 23'd4194304;
        endcase
        return r;
    endfunction

endpackage

/* src/dlr_front.sv */
// front end: takes frames, sums the active channels, divides by the count
// depends on dlr_pkg; feeds mono words into dlr_queue
module dlr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  dlr_pkg::cfg_t       cfg,
    input  logic                push,
    output logic                full,
    input  dlr_pkg::sample_t    chan [dlr_pkg::MAX_CHANNELS],
    input  logic                block_end,
    output logic                q_push,
    output dlr_pkg::frame_t     q_data,
    input  logic                q_full
);
    import dlr_pkg::*;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [SUM_BITS-1:0]     mag_reg;
    logic                    neg_reg;
    logic                    be_reg;
    chan_cnt_t               n_reg;
    chan_cnt_t               n_eff;
    logic signed [SUM_BITS-1:0] sum;
    logic [PROD_BITS-1:0]    prod;
    logic [SAMPLE_BITS:0]    quot;
    logic [SAMPLE_BITS:0]    mono_ext;
    logic                    accept;

    // clamp channel count to 1..MAX_CHANNELS
    always_comb
    begin
        if (cfg.channel_count == '0)
            n_eff = CHAN_BITS'(1);
        else if (cfg.channel_count > CHAN_BITS'(MAX_CHANNELS))
            n_eff = CHAN_BITS'(MAX_CHANNELS);
        else
            n_eff = cfg.channel_count;
    end

    // sum of the active channels
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (CHAN_BITS'(i) < n_eff)
                sum = sum + SUM_BITS'(chan[i]);
        end
    end

    // one frame in the divide stage at a time, passes on when the queue has room
    assign q_push        = s1_valid_reg && !q_full;
    assign full          = s1_valid_reg && q_full;
    assign accept        = push && !full;
    assign s1_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // frame registers: magnitude and sign of the sum
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= sum[SUM_BITS-1];
            mag_reg <= sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
            be_reg  <= block_end;
            n_reg   <= n_eff;
        end
    end

    // divide by reciprocal multiply, truncating toward zero
    assign prod     = PROD_BITS'(mag_reg) * PROD_BITS'(recip(n_reg));
    assign quot     = prod[RECIP_SHIFT +: SAMPLE_BITS+1];
    assign mono_ext = neg_reg ? (SAMPLE_BITS+1)'(-quot) : quot;

    assign q_data.mono      = mono_ext[SAMPLE_BITS-1:0];
    assign q_data.block_end = be_reg;

endmodule

/* src/dlr_queue.sv */
// short first-in first-out queue of mono frames between front and back
// depends on dlr_pkg for the frame type
module dlr_queue #(
    parameter int DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dlr_pkg::frame_t push_data,
    output logic            full,
    input  logic            pop,
    output dlr_pkg::frame_t pop_data,
    output logic            empty
);
    import dlr_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    frame_t                 mem [DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg;
    logic [PTR_BITS-1:0]    rd_ptr_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/dlr_back.sv */
// back end: phase accumulator, interpolation and held-sample runs
// depends on dlr_pkg; reads frames from dlr_queue, drives the result word
module dlr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dlr_pkg::cfg_t    cfg,
    input  logic             q_empty,
    input  dlr_pkg::frame_t  q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output dlr_pkg::sample_t out_sample,
    output logic             run_last
);
    import dlr_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_INTERP,
        B_HOLD
    } state_t;

    state_t  state_reg, state_next;
    phase_t  ph_reg, ph_next;
    sample_t prev_reg, prev_next;
    logic    at_start_reg, at_start_next;
    sample_t cur_reg, cur_next;
    logic    be_reg, be_next;
    logic    out_valid_reg, out_valid_next;
    sample_t out_sample_reg, out_sample_next;
    logic    run_last_reg, run_last_next;

    phase_t                  step_eff;
    logic [PHASE_BITS:0]     nph;
    logic                    below_one;
    logic                    slot_free;
    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [FRAC_BITS:0]       frac;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod;
    logic [SAMPLE_BITS+FRAC_BITS+2:0]        acc;
    sample_t                 lerp;
    logic                    last_interp;
    logic                    last_hold;

    // clamp the step to its legal range
    always_comb
    begin
        if (cfg.phase_step < PHASE_BITS'(STEP_MIN))
            step_eff = PHASE_BITS'(STEP_MIN);
        else if (cfg.phase_step > PHASE_BITS'(STEP_MAX))
            step_eff = PHASE_BITS'(STEP_MAX);
        else
            step_eff = cfg.phase_step;
    end

    // next phase point and end-of-run lookahead
    assign nph         = {1'b0, ph_reg} + {1'b0, step_eff};
    assign below_one   = (ph_reg < PHASE_BITS'(PHASE_ONE));
    assign last_hold   = (nph >= (PHASE_BITS+1)'(PHASE_ONE));
    assign last_interp = be_reg ? (nph >= (PHASE_BITS+1)'(2*PHASE_ONE)) : last_hold;

    // prev + (cur - prev) * frac, rounded half up
    assign diff = (SAMPLE_BITS+1)'(cur_reg) - (SAMPLE_BITS+1)'(prev_reg);
    assign frac = {1'b0, ph_reg[FRAC_BITS-1:0]};
    assign prod = diff * frac;
    assign acc  = {{3{prev_reg[SAMPLE_BITS-1]}}, prev_reg, {FRAC_BITS{1'b0}}}
                + {prod[SAMPLE_BITS+FRAC_BITS+1], prod}
                + (SAMPLE_BITS+FRAC_BITS+3)'(PHASE_ONE / 2);
    assign lerp = acc[FRAC_BITS +: SAMPLE_BITS];

    assign slot_free = !out_valid_reg || pop;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        prev_next       = prev_reg;
        at_start_next   = at_start_reg;
        cur_next        = cur_reg;
        be_next         = be_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_sample_next = out_sample_reg;
        run_last_next   = run_last_reg;
        q_pop           = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data.mono;
                    be_next  = q_data.block_end;
                    if (!at_start_reg)
                        state_next = B_INTERP;
                    else if (q_data.block_end)
                        state_next = B_HOLD;
                    else
                    begin
                        // first frame of a block only seeds the previous sample
                        prev_next     = q_data.mono;
                        at_start_next = 1'b0;
                    end
                end
            end
            B_INTERP:
            begin
                if (below_one)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = lerp;
                        run_last_next   = last_interp;
                        ph_next         = nph[PHASE_BITS-1:0];
                    end
                end
                else
                begin
                    ph_next = ph_reg - PHASE_BITS'(PHASE_ONE);
                    if (be_reg)
                        state_next = B_HOLD;
                    else
                    begin
                        prev_next     = cur_reg;
                        at_start_next = 1'b0;
                        state_next    = B_IDLE;
                    end
                end
            end
            B_HOLD:
            begin
                if (below_one)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = cur_reg;
                        run_last_next   = last_hold;
                        ph_next         = nph[PHASE_BITS-1:0];
                    end
                end
                else
                begin
                    ph_next       = ph_reg - PHASE_BITS'(PHASE_ONE);
                    prev_next     = cur_reg;
                    at_start_next = 1'b1;
                    state_next    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            ph_reg         <= '0;
            prev_reg       <= '0;
            at_start_reg   <= 1'b1;
            cur_reg        <= '0;
            be_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            run_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ph_reg         <= ph_next;
            prev_reg       <= prev_next;
            at_start_reg   <= at_start_next;
            cur_reg        <= cur_next;
            be_reg         <= be_next;
            out_valid_reg  <= out_valid_next;
            out_sample_reg <= out_sample_next;
            run_last_reg   <= run_last_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_last   = run_last_reg;

endmodule

/* src/downmix_linear_resampler.sv */
// Downmixing linear-interpolation resampler. Each pushed frame is averaged to
// one mono Q1.15 sample in the front end (one frame per clock while the queue
// has room, registered once before it enters the queue) and queued. The back end
// then emits one result word per clock while pop keeps up, for each phase point
// in the interval since the previous frame, plus held words after a block_end
// frame. The back end fetches a frame, emits its result words (at most 32),
// takes each phase wrap (none to two) and fetches the next frame only once it is
// through with the current one; its single output stage holds a word until pop.
// Configuration: phase_step at byte address 0, channel_count at byte address 4.
// depends on dlr_pkg, dlr_front, dlr_queue, dlr_back
module downmix_linear_resampler #(
    parameter int QUEUE_DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  dlr_pkg::sample_t                chan0,
    input  dlr_pkg::sample_t                chan1,
    input  dlr_pkg::sample_t                chan2,
    input  dlr_pkg::sample_t                chan3,
    input  dlr_pkg::sample_t                chan4,
    input  dlr_pkg::sample_t                chan5,
    input  dlr_pkg::sample_t                chan6,
    input  dlr_pkg::sample_t                chan7,
    input  logic                            block_end,
    output logic                            empty,
    input  logic                            pop,
    output dlr_pkg::sample_t                out_sample,
    output logic                            run_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dlr_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [dlr_pkg::DATA_BITS-1:0]   pwdata,
    output logic [dlr_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready
);
    import dlr_pkg::*;

    phase_t    phase_step_reg;
    chan_cnt_t channel_count_reg;
    cfg_t      cfg;
    reg_idx_t  reg_idx;
    logic      cfg_write;
    sample_t   chans [MAX_CHANNELS];
    logic      fq_push;
    frame_t    fq_data;
    logic      fq_full;
    logic      qb_pop;
    frame_t    qb_data;
    logic      qb_empty;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= PHASE_BITS'(STEP_RESET);
            channel_count_reg <= CHAN_BITS'(CHAN_RESET);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PHASE_STEP:    phase_step_reg    <= pwdata[PHASE_BITS-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CHAN_BITS-1:0];
                default:           phase_step_reg    <= phase_step_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_PHASE_STEP:    prdata = DATA_BITS'(phase_step_reg);
            REG_CHANNEL_COUNT: prdata = DATA_BITS'(channel_count_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.phase_step    = phase_step_reg;
    assign cfg.channel_count = channel_count_reg;

    // channel ports gathered into a row
    assign chans[0] = chan0;
    assign chans[1] = chan1;
    assign chans[2] = chan2;
    assign chans[3] = chan3;
    assign chans[4] = chan4;
    assign chans[5] = chan5;
    assign chans[6] = chan6;
    assign chans[7] = chan7;

    dlr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .chan      (chans),
        .block_end (block_end),
        .q_push    (fq_push),
        .q_data    (fq_data),
        .q_full    (fq_full)
    );

    dlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_data (fq_data),
        .full      (fq_full),
        .pop       (qb_pop),
        .pop_data  (qb_data),
        .empty     (qb_empty)
    );

    dlr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_empty    (qb_empty),
        .q_data     (qb_data),
        .q_pop      (qb_pop),
        .empty      (empty),
        .pop        (pop),
        .out_sample (out_sample),
        .run_last   (run_last)
    );

endmodule

/* src/dlr_checker.sv */
// port-level checks of the downmix resampler, attached by bind
// depends on dlr_pkg, assert_macros.svh and downmix_linear_resampler
`include "assert_macros.svh"

module dlr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  dlr_pkg::sample_t              out_sample,
    input  logic                          run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [dlr_pkg::DATA_BITS-1:0] pwdata,
    input  logic [dlr_pkg::DATA_BITS-1:0] prdata,
    input  logic                          pready
);
    import dlr_pkg::*;

    // the port never inserts wait states
    `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready)

    // a waiting result word holds until popped
    `ASSERT_NEXT(a_word_holds, clk, rst_n, !empty && !pop, !empty && $stable(out_sample) && $stable(run_last))

    // out of reset there is no word waiting and room for a frame
    `ASSERT_IMPLY(a_reset_clean, clk, rst_n, $rose(rst_n), empty && !full)

    // channel count reads back what was written, masked to its width
    `ASSERT_IMPLY(a_count_readback, clk, rst_n, $past(psel && penable && pwrite && paddr[2]) && paddr[2] && rst_n && $past(rst_n), prdata == DATA_BITS'($past(pwdata[CHAN_BITS-1:0])))

endmodule

bind downmix_linear_resampler dlr_checker u_dlr_checker (.*);
